// ===== rtl/fss_pkg.sv =====
// Shared types and codes of the fan speed shaper.
package fss_pkg;

    typedef enum logic [1:0] {
        FUNC_REQ  = 2'd0,
        FUNC_ACK  = 2'd1,
        FUNC_TACH = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        OP_REQ,
        OP_ACK,
        OP_TACH
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_DIV1,
        S_MUL2,
        S_DIV2,
        S_OUT,
        S_TACH
    } t_state;

    typedef enum logic [2:0] {
        CFG_MAX_POWER       = 3'd0,
        CFG_OFF_BELOW       = 3'd1,
        CFG_STARTUP_VOLTAGE = 3'd2,
        CFG_KICK_TICKS      = 3'd3,
        CFG_MIN_INTERVAL    = 3'd4,
        CFG_STALL_LIMIT     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] kick_ticks;
        logic [15:0] min_interval;
        logic [3:0]  stall_limit;
    } t_timing;

    localparam logic [15:0] KICK_TICKS_RST   = 16'd100;
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd100;
    localparam logic [3:0]  STALL_LIMIT_RST  = 4'd10;
    localparam logic [3:0]  MISS_MAX         = 4'd15;

endpackage

// ===== rtl/fan_speed_shaper.sv =====
// Top level of the fan speed shaper: configuration registers, front end and back end.
// A speed request runs the shared multiplier and divider sequence and then sends none, one or two
// PWM commands; an acknowledge is taken in S_IDLE and a tach check passes through S_TACH;
// a two-entry queue behind the input lets transfers continue while the back end works, and a
// result register lets the back end go on while a result waits to be taken.
module fan_speed_shaper import fss_pkg::*; #(
    parameter int DUTY_BITS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [DUTY_BITS-1:0] i_requested_speed,
    input  logic [TIME_BITS-1:0] i_request_time,
    input  logic [15:0]          i_tach_freq,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_result_kind,
    output logic [TIME_BITS-1:0] o_pwm_time,
    output logic [DUTY_BITS-1:0] o_pwm_duty,
    output logic                 o_last_of_run,
    output logic                 o_stall_fault,
    output logic [3:0]           o_miss_count
);

    localparam int SPD_BITS = (DUTY_BITS < 16) ? DUTY_BITS : 16;

    logic [DUTY_BITS-1:0] r_duty_cap;
    logic [DUTY_BITS-1:0] r_off_floor;
    logic [DUTY_BITS-1:0] r_startup_voltage;
    t_timing              r_timing;
    logic [DUTY_BITS-1:0] w_cfg_duty;

    logic                 w_q_valid;
    t_op                  w_q_op;
    logic [DUTY_BITS-1:0] w_q_speed;
    logic [TIME_BITS-1:0] w_q_time;
    logic                 w_q_tach_zero;
    logic                 w_q_pop;

    assign w_cfg_duty = DUTY_BITS'(i_cfg_data[SPD_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_cap            <= DUTY_BITS'({SPD_BITS{1'b1}});
            r_off_floor           <= '0;
            r_startup_voltage     <= '0;
            r_timing.kick_ticks   <= KICK_TICKS_RST;
            r_timing.min_interval <= MIN_INTERVAL_RST;
            r_timing.stall_limit  <= STALL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_POWER:       r_duty_cap            <= w_cfg_duty;
                CFG_OFF_BELOW:       r_off_floor           <= w_cfg_duty;
                CFG_STARTUP_VOLTAGE: r_startup_voltage     <= w_cfg_duty;
                CFG_KICK_TICKS:      r_timing.kick_ticks   <= i_cfg_data;
                CFG_MIN_INTERVAL:    r_timing.min_interval <= i_cfg_data;
                CFG_STALL_LIMIT:     r_timing.stall_limit  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    fss_front #(
        .DUTY_BITS (DUTY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_requested_speed (i_requested_speed),
        .i_request_time    (i_request_time),
        .i_tach_freq       (i_tach_freq),
        .o_q_valid         (w_q_valid),
        .o_q_op            (w_q_op),
        .o_q_speed         (w_q_speed),
        .o_q_time          (w_q_time),
        .o_q_tach_zero     (w_q_tach_zero),
        .i_q_pop           (w_q_pop)
    );

    fss_back #(
        .DUTY_BITS (DUTY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_q_op            (w_q_op),
        .i_q_speed         (w_q_speed),
        .i_q_time          (w_q_time),
        .i_q_tach_zero     (w_q_tach_zero),
        .o_q_pop           (w_q_pop),
        .i_duty_cap        (r_duty_cap),
        .i_off_floor       (r_off_floor),
        .i_startup_voltage (r_startup_voltage),
        .i_timing          (r_timing),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_kind     (o_result_kind),
        .o_pwm_time        (o_pwm_time),
        .o_pwm_duty        (o_pwm_duty),
        .o_last_of_run     (o_last_of_run),
        .o_stall_fault     (o_stall_fault),
        .o_miss_count      (o_miss_count)
    );

endmodule

// ===== rtl/fss_front.sv =====
// Front end: accepts items, classifies the function code and queues the work.
module fss_front import fss_pkg::*; #(
    parameter int DUTY_BITS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [DUTY_BITS-1:0] i_requested_speed,
    input  logic [TIME_BITS-1:0] i_request_time,
    input  logic [15:0]          i_tach_freq,
    output logic                 o_q_valid,
    output t_op                  o_q_op,
    output logic [DUTY_BITS-1:0] o_q_speed,
    output logic [TIME_BITS-1:0] o_q_time,
    output logic                 o_q_tach_zero,
    input  logic                 i_q_pop
);

    localparam int SPD_BITS = (DUTY_BITS < 16) ? DUTY_BITS : 16;
    localparam int TIN_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam logic [1:0] DEPTH = 2'd2;

    t_op                  r_op    [2];
    logic [DUTY_BITS-1:0] r_speed [2];
    logic [TIME_BITS-1:0] r_time  [2];
    logic                 r_tzero [2];
    logic                 r_wr;
    logic                 r_rd;
    logic [1:0]           r_count;
    logic [1:0]           n_count;

    t_op                  w_op;
    logic                 w_keep;
    logic                 w_push;
    logic [DUTY_BITS-1:0] w_speed;
    logic [TIME_BITS-1:0] w_time;

    always_comb begin
        w_op   = OP_REQ;
        w_keep = 1'b1;
        unique case (t_func'(i_func))
            FUNC_REQ:  w_op = OP_REQ;
            FUNC_ACK:  w_op = OP_ACK;
            FUNC_TACH: w_op = OP_TACH;
            default:   w_keep = 1'b0;
        endcase
    end

    assign w_speed    = DUTY_BITS'(i_requested_speed[SPD_BITS-1:0]);
    assign w_time     = TIME_BITS'(i_request_time[TIN_BITS-1:0]);
    assign o_in_stall = (r_count == DEPTH);
    assign w_push     = i_in_valid && !o_in_stall && w_keep;

    always_comb begin
        n_count = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_op[r_wr]    <= w_op;
            r_speed[r_wr] <= w_speed;
            r_time[r_wr]  <= w_time;
            r_tzero[r_wr] <= (i_tach_freq == 16'd0);
        end
    end

    assign o_q_valid     = (r_count != 2'd0);
    assign o_q_op        = r_op[r_rd];
    assign o_q_speed     = r_speed[r_rd];
    assign o_q_time      = r_time[r_rd];
    assign o_q_tach_zero = r_tzero[r_rd];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH)
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_count != 2'd0))
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_q_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("push lost");

endmodule

// ===== rtl/fss_back.sv =====
// Back end: sequences duty shaping, command timing and tach checks onto the output.
module fss_back import fss_pkg::*; #(
    parameter int DUTY_BITS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_op                  i_q_op,
    input  logic [DUTY_BITS-1:0] i_q_speed,
    input  logic [TIME_BITS-1:0] i_q_time,
    input  logic                 i_q_tach_zero,
    output logic                 o_q_pop,
    input  logic [DUTY_BITS-1:0] i_duty_cap,
    input  logic [DUTY_BITS-1:0] i_off_floor,
    input  logic [DUTY_BITS-1:0] i_startup_voltage,
    input  t_timing              i_timing,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_result_kind,
    output logic [TIME_BITS-1:0] o_pwm_time,
    output logic [DUTY_BITS-1:0] o_pwm_duty,
    output logic                 o_last_of_run,
    output logic                 o_stall_fault,
    output logic [3:0]           o_miss_count
);

    localparam int PW = 2 * DUTY_BITS;
    localparam logic [DUTY_BITS-1:0] FULL = {DUTY_BITS{1'b1}};
    localparam logic [DUTY_BITS-1:0] HALF = FULL >> 1;

    t_state               r_state;
    t_state               n_state;

    logic [DUTY_BITS-1:0] r_speed;
    logic [TIME_BITS-1:0] r_req_time;
    logic                 r_tzero;
    logic [PW-1:0]        r_prod;
    logic [DUTY_BITS-1:0] r_v;
    logic [DUTY_BITS-1:0] r_duty;
    logic [TIME_BITS-1:0] r_tcmd;
    logic                 r_kick;

    logic [DUTY_BITS-1:0] r_computed;
    logic [DUTY_BITS-1:0] r_applied;
    logic [TIME_BITS-1:0] r_last_time;
    logic [3:0]           r_zero_reads;
    logic                 r_stopped;

    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [TIME_BITS-1:0] r_out_time;
    logic [DUTY_BITS-1:0] r_out_duty;
    logic                 r_out_last;
    logic                 r_out_fault;
    logic [3:0]           r_out_miss;

    logic                 w_out_free;
    logic                 w_pop;
    logic                 w_load_kick;
    logic                 w_load_cmd;
    logic                 w_load_tach;
    logic                 w_same;

    logic [DUTY_BITS-1:0] w_ma;
    logic [DUTY_BITS-1:0] w_mb;
    logic [PW:0]          w_x;
    logic [PW:0]          w_s;
    logic [DUTY_BITS-1:0] w_q;
    logic [DUTY_BITS-1:0] w_v1;
    logic [DUTY_BITS-1:0] w_v2;
    logic [DUTY_BITS-1:0] w_vc;
    logic [DUTY_BITS-1:0] w_diff;
    logic                 w_kick;

    logic [TIME_BITS-1:0] w_add_a;
    logic [15:0]          w_add_b;
    logic [TIME_BITS:0]   w_sum;
    logic [TIME_BITS-1:0] w_sat;
    logic [TIME_BITS-1:0] w_tstart;

    logic [3:0]           w_zr_next;
    logic                 w_fault;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // rounded fraction product divided by FULL: (x + (x >> n) + 1) >> n
    assign w_x = {1'b0, r_prod} + (PW + 1)'(HALF);
    assign w_s = w_x + (w_x >> DUTY_BITS) + (PW + 1)'(1);
    assign w_q = w_s[PW-1:DUTY_BITS];

    assign w_ma = (r_state == S_MUL1) ? (FULL - i_startup_voltage) : r_v;
    assign w_mb = (r_state == S_MUL1) ? r_speed : i_duty_cap;

    assign w_v1 = (i_startup_voltage != '0 && r_speed != '0) ?
                  (w_q + i_startup_voltage) : r_speed;
    assign w_v2 = (w_v1 < i_off_floor) ? '0 : w_v1;
    assign w_vc = (w_q > i_duty_cap) ? i_duty_cap : w_q;
    assign w_same = (w_vc == r_applied);

    assign w_diff = w_vc - r_applied;
    assign w_kick = (w_vc != '0) && (w_vc < i_duty_cap) && (i_timing.kick_ticks != 16'd0) &&
                    ((r_applied == '0) || ((w_vc > r_applied) && (w_diff > HALF)));

    // shared saturating time adder
    assign w_add_a  = (r_state == S_OUT) ? r_tcmd : r_last_time;
    assign w_add_b  = (r_state == S_OUT) ? i_timing.kick_ticks : i_timing.min_interval;
    assign w_sum    = {1'b0, w_add_a} + (TIME_BITS + 1)'(w_add_b);
    assign w_sat    = w_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];
    assign w_tstart = (r_req_time > w_sat) ? r_req_time : w_sat;

    always_comb begin
        w_zr_next = 4'd0;
        w_fault   = 1'b0;
        if (r_tzero && r_applied != '0) begin
            w_zr_next = (r_zero_reads < MISS_MAX) ? (r_zero_reads + 4'd1) : r_zero_reads;
            w_fault   = (w_zr_next >= i_timing.stall_limit);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_op)
                        OP_REQ:  n_state = S_MUL1;
                        OP_TACH: n_state = S_TACH;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL1: n_state = S_DIV1;
            S_DIV1: n_state = S_MUL2;
            S_MUL2: n_state = S_DIV2;
            S_DIV2: n_state = w_same ? S_IDLE : S_OUT;
            S_OUT: begin
                if (w_out_free && !r_kick) begin
                    n_state = S_IDLE;
                end
            end
            S_TACH: begin
                if (r_stopped || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_pop       = 1'b0;
        w_load_kick = 1'b0;
        w_load_cmd  = 1'b0;
        w_load_tach = 1'b0;
        unique case (r_state)
            S_IDLE: w_pop = i_q_valid;
            S_OUT: begin
                w_load_kick = w_out_free && r_kick;
                w_load_cmd  = w_out_free && !r_kick;
            end
            S_TACH:  w_load_tach = w_out_free && !r_stopped;
            default: ;
        endcase
    end

    assign o_q_pop = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_computed   <= '0;
            r_applied    <= '0;
            r_last_time  <= '0;
            r_zero_reads <= 4'd0;
            r_stopped    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_kick       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pop && i_q_op == OP_ACK) begin
                r_applied <= r_computed;
            end
            if (r_state == S_DIV2) begin
                r_computed <= w_vc;
                r_kick     <= w_kick;
            end
            if (w_load_kick) begin
                r_kick <= 1'b0;
            end
            if (w_load_cmd) begin
                r_last_time <= r_tcmd;
            end
            if (w_load_tach) begin
                r_zero_reads <= w_zr_next;
                if (w_fault) begin
                    r_stopped <= 1'b1;
                end
            end
            if (w_load_kick || w_load_cmd || w_load_tach) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_speed    <= i_q_speed;
            r_req_time <= i_q_time;
            r_tzero    <= i_q_tach_zero;
        end
        if (r_state == S_MUL1 || r_state == S_MUL2) begin
            r_prod <= w_ma * w_mb;
        end
        if (r_state == S_DIV1) begin
            r_v <= w_v2;
        end
        if (r_state == S_DIV2) begin
            r_duty <= w_vc;
            r_tcmd <= w_tstart;
        end
        if (w_load_kick) begin
            r_tcmd <= w_sat;
        end
        if (w_load_kick || w_load_cmd) begin
            r_out_kind  <= 1'b0;
            r_out_time  <= r_tcmd;
            r_out_duty  <= w_load_kick ? i_duty_cap : r_duty;
            r_out_last  <= w_load_cmd;
            r_out_fault <= 1'b0;
            r_out_miss  <= r_zero_reads;
        end
        if (w_load_tach) begin
            r_out_kind  <= 1'b1;
            r_out_time  <= '0;
            r_out_duty  <= r_applied;
            r_out_last  <= 1'b1;
            r_out_fault <= w_fault;
            r_out_miss  <= w_zr_next;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_pwm_time    = r_out_time;
    assign o_pwm_duty    = r_out_duty;
    assign o_last_of_run = r_out_last;
    assign o_stall_fault = r_out_fault;
    assign o_miss_count  = r_out_miss;

    a_tach_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind) |-> (r_out_time == '0))
        else $error("tach status with nonzero time");

    a_kick_is_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> !r_out_kind)
        else $error("non-final result that is not a PWM command");

    a_fault_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fault) |-> r_stopped)
        else $error("stall fault without monitor stop");

    a_kick_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kick |-> (r_state == S_OUT))
        else $error("pending kick outside output state");

endmodule

// ===== tb/sv/fan_speed_shaper_checker.sv =====
// Checker for the fan speed shaper: mirrors its registers and state, predicts and compares results.
module fan_speed_shaper_checker import fss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_requested_speed,
    input  logic [31:0] i_request_time,
    input  logic [15:0] i_tach_freq,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_result_kind,
    input  logic [31:0] i_pwm_time,
    input  logic [15:0] i_pwm_duty,
    input  logic        i_last_of_run,
    input  logic        i_stall_fault,
    input  logic [3:0]  i_miss_count,
    output int          o_fail_count,
    output int          o_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        KIND_PWM  = 1'b0;
    localparam logic        KIND_TACH = 1'b1;
    localparam logic [15:0] FULL      = 16'hFFFF;
    localparam logic [31:0] TICK_MAX  = 32'hFFFF_FFFF;
    localparam int          PRINT_MAX = 30;

    typedef struct packed {
        logic        kind;
        logic [31:0] at;
        logic [15:0] duty;
        logic        last;
        logic        fault;
        logic [3:0]  misses;
    } t_fan_result;

    t_fan_result owed_results[$];

    logic [15:0] duty_cap, off_floor, startup_v, kick_ticks, min_gap;
    logic [3:0]  stall_limit;
    logic [15:0] computed, applied;
    logic [31:0] last_cmd;
    logic [3:0]  zero_reads;
    logic        monitor_off;
    int          fail_count = 0;

    function automatic logic [15:0] frac_product(logic [15:0] a, logic [15:0] b);
        logic [32:0] p;
        p = a * b + 33'(FULL >> 1);
        return 16'(p / FULL);
    endfunction

    function automatic logic [31:0] tick_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TICK_MAX : s[31:0];
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= PRINT_MAX) $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    task automatic push_result(logic kind, logic [31:0] at, logic [15:0] duty, logic last,
                               logic fault);
        t_fan_result r;
        r.kind = kind;
        r.at = at;
        r.duty = duty;
        r.last = last;
        r.fault = fault;
        r.misses = zero_reads;
        owed_results.push_back(r);
    endtask

    task automatic shape_fan_item(logic [1:0] fn, logic [15:0] spd, logic [31:0] rt,
                                  logic [15:0] tach);
        logic [15:0] v;
        logic [31:0] at;
        logic        stall_hit;
        case (t_func'(fn))
            FUNC_REQ: begin
                v = spd;
                if (startup_v != 0 && v != 0) v = frac_product(FULL - startup_v, v) + startup_v;
                if (v < off_floor) v = '0;
                v = frac_product(v, duty_cap);
                if (v > duty_cap) v = duty_cap;
                computed = v;
                if (v != applied) begin
                    at = tick_sum(last_cmd, {16'd0, min_gap});
                    if (rt > at) at = rt;
                    if (v != 0 && v < duty_cap && kick_ticks != 0 &&
                        (applied == 0 || (v > applied && v - applied > (FULL >> 1)))) begin
                        push_result(KIND_PWM, at, duty_cap, 1'b0, 1'b0);
                        at = tick_sum(at, {16'd0, kick_ticks});
                    end
                    push_result(KIND_PWM, at, v, 1'b1, 1'b0);
                    last_cmd = at;
                end
            end
            FUNC_ACK: applied = computed;
            FUNC_TACH: begin
                if (!monitor_off) begin
                    stall_hit = 1'b0;
                    if (tach == 0 && applied != 0) begin
                        if (zero_reads != MISS_MAX) zero_reads++;
                        if (zero_reads >= stall_limit) begin
                            stall_hit = 1'b1;
                            monitor_off = 1'b1;
                        end
                    end else begin
                        zero_reads = '0;
                    end
                    push_result(KIND_TACH, '0, applied, 1'b1, stall_hit);
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    task automatic check_result();
        t_fan_result want;
        if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result: kind %0d time %0d duty %0d",
                                      i_result_kind, i_pwm_time, i_pwm_duty));
            return;
        end
        want = owed_results.pop_front();
        compare_field("result_kind", i_result_kind, want.kind);
        compare_field("pwm_time", i_pwm_time, want.at);
        compare_field("pwm_duty", i_pwm_duty, want.duty);
        compare_field("last_of_run", i_last_of_run, want.last);
        compare_field("stall_fault", i_stall_fault, want.fault);
        compare_field("miss_count", i_miss_count, want.misses);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            duty_cap    = FULL;
            off_floor   = '0;
            startup_v   = '0;
            kick_ticks  = KICK_TICKS_RST;
            min_gap     = MIN_INTERVAL_RST;
            stall_limit = STALL_LIMIT_RST;
            computed    = '0;
            applied     = '0;
            last_cmd    = '0;
            zero_reads  = '0;
            monitor_off = 1'b0;
            owed_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MAX_POWER:       duty_cap = i_cfg_data;
                    CFG_OFF_BELOW:       off_floor = i_cfg_data;
                    CFG_STARTUP_VOLTAGE: startup_v = i_cfg_data;
                    CFG_KICK_TICKS:      kick_ticks = i_cfg_data;
                    CFG_MIN_INTERVAL:    min_gap = i_cfg_data;
                    CFG_STALL_LIMIT:     stall_limit = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                shape_fan_item(i_func, i_requested_speed, i_request_time, i_tach_freq);
            end
            if (i_out_valid && !i_out_stall) check_result();
        end
        o_owed = owed_results.size();
        o_fail_count = fail_count;
    end

endmodule

// ===== tb/sv/fan_speed_shaper_tb.sv =====
// Testbench top for the fan speed shaper: clock, reset, stimulus, receiver stalls and verdict.
module fan_speed_shaper_tb import fss_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int QUIET_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_index = CFG_MAX_POWER;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    t_func       func = FUNC_NONE;
    logic [15:0] speed = '0;
    logic [31:0] req_time = '0;
    logic [15:0] tach = '0;
    logic        out_stall = 1'b0;

    logic        in_stall, out_valid, result_kind, last_of_run, stall_fault;
    logic [31:0] pwm_time;
    logic [15:0] pwm_duty;
    logic [3:0]  miss_count;
    int          fail_count, owed;

    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    int          cycle_count = 0;
    logic [31:0] now_tick = '0;
    logic [15:0] off_level = '0;

    always #4 clk = ~clk;

    fan_speed_shaper u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_func            (func),
        .i_requested_speed (speed),
        .i_request_time    (req_time),
        .i_tach_freq       (tach),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_result_kind     (result_kind),
        .o_pwm_time        (pwm_time),
        .o_pwm_duty        (pwm_duty),
        .o_last_of_run     (last_of_run),
        .o_stall_fault     (stall_fault),
        .o_miss_count      (miss_count)
    );

    fan_speed_shaper_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_func            (func),
        .i_requested_speed (speed),
        .i_request_time    (req_time),
        .i_tach_freq       (tach),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_result_kind     (result_kind),
        .i_pwm_time        (pwm_time),
        .i_pwm_duty        (pwm_duty),
        .i_last_of_run     (last_of_run),
        .i_stall_fault     (stall_fault),
        .i_miss_count      (miss_count),
        .o_fail_count      (fail_count),
        .o_owed            (owed)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            out_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(logic [15:0] mp, logic [15:0] ob, logic [15:0] sv,
                                 logic [15:0] kt, logic [15:0] mi, logic [3:0] sl);
        cfg_write(CFG_MAX_POWER, mp);
        cfg_write(CFG_OFF_BELOW, ob);
        cfg_write(CFG_STARTUP_VOLTAGE, sv);
        cfg_write(CFG_KICK_TICKS, kt);
        cfg_write(CFG_MIN_INTERVAL, mi);
        cfg_write(CFG_STALL_LIMIT, {12'd0, sl});
        cfg_we <= 1'b0;
        off_level = ob;
    endtask

    task automatic set_idling(int snd, int rcv);
        snd_idle_pct = snd;
        rcv_stall_pct <= rcv;
    endtask

    task automatic send_item(t_func fn, logic [15:0] spd, logic [31:0] rt, logic [15:0] tf);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        speed    <= spd;
        req_time <= rt;
        tach     <= tf;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(int count, bit wide_time);
        int          done;
        int          pick;
        t_func       fn;
        logic [15:0] spd;
        logic [31:0] rt;
        logic [15:0] tf;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            spd = 16'($urandom);
            tf = 16'($urandom);
            now_tick += 32'($urandom_range(400));
            rt = wide_time ? 32'($urandom) : now_tick;
            if (pick < 45) begin
                fn = FUNC_REQ;
                case ($urandom_range(9))
                    0: spd = '0;
                    1: spd = '1;
                    2: spd = off_level + 16'($urandom_range(2)) - 16'd1;
                    default: ;
                endcase
            end else if (pick < 75) begin
                fn = FUNC_ACK;
            end else if (pick < 97) begin
                fn = FUNC_TACH;
                if ($urandom_range(3) == 0) tf = '0;
            end else begin
                fn = FUNC_NONE;
            end
            send_item(fn, spd, rt, tf);
            if (fn != FUNC_NONE) done++;
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: boundaries, kick rules, skips, tach counting
        load_settings(16'hFFFF, 16'd0, 16'd0, 16'd100, 16'd100, 4'd15);
        send_item(FUNC_TACH, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_REQ, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_REQ, 16'hFFFF, 32'd0, 16'd0);
        send_item(FUNC_ACK, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_TACH, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_TACH, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_TACH, 16'd0, 32'd0, 16'hFFFF);
        send_item(FUNC_REQ, 16'd1000, 32'd5, 16'd0);
        send_item(FUNC_ACK, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_REQ, 16'd40000, 32'd1000, 16'd0);
        send_item(FUNC_ACK, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_REQ, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_ACK, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_REQ, 16'd30000, 32'd5000, 16'd0);
        send_item(FUNC_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(FUNC_ACK, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_REQ, 16'd30000, 32'd0, 16'd0);
        settle();
        load_settings(16'd40000, 16'd20000, 16'd10000, 16'd0, 16'd0, 4'd15);
        send_item(FUNC_REQ, 16'd5000, 32'd0, 16'd0);
        send_item(FUNC_REQ, 16'hFFFF, 32'd0, 16'd0);
        send_item(FUNC_ACK, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_TACH, 16'd0, 32'd0, 16'd0);
        send_item(FUNC_REQ, 16'hFFFF, 32'd6000, 16'd0);
        settle();
        now_tick = 32'd10000;

        // no idling; one long receiver hold-off to back up the input
        load_settings(16'hFFFF, 16'd0, 16'd0, 16'd100, 16'd100, 4'd15);
        set_idling(0, 0);
        hold_req <= 1'b1;
        send_random(170, 1'b0);
        settle();

        load_settings(16'd50000, 16'd8000, 16'd12000, 16'hFFFF, 16'd0, 4'd15);
        set_idling(88, 0);
        send_random(170, 1'b0);
        settle();

        load_settings(16'($urandom), 16'($urandom_range(30000)), 16'($urandom),
                      16'($urandom_range(1, 500)), 16'($urandom_range(500)), 4'd15);
        set_idling(0, 88);
        send_random(170, 1'b0);
        settle();

        load_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 4'd15);
        set_idling(31, 31);
        send_random(150, 1'b0);
        settle();

        // zero power: duty drops to zero, so zero readings never count
        load_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 4'd1);
        send_item(FUNC_REQ, 16'($urandom), now_tick, 16'd0);
        send_item(FUNC_ACK, 16'd0, 32'd0, 16'd0);
        send_random(60, 1'b0);
        settle();

        // stall limit zero trips the monitor; full-range times saturate
        load_settings(16'hFFFF, 16'd0, 16'd0, 16'd100, 16'd100, 4'd0);
        set_idling(0, 0);
        send_item(FUNC_REQ, 16'd30000, 32'hFFFF_FFF0, 16'd0);
        send_random(80, 1'b1);
        settle();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fss_pkg.sv
rtl/fss_front.sv
rtl/fss_back.sv
rtl/fan_speed_shaper.sv
tb/sv/fan_speed_shaper_checker.sv
tb/sv/fan_speed_shaper_tb.sv
